### hw/rtl/vrth_pkg.sv
// Shared constants and result codes for the vertical ray triangle height core.
`default_nettype none
package vrth_pkg;

  localparam int HEIGHT_BITS = 23;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_MAX = {HEIGHT_BITS{1'b1}};

  typedef enum logic [1:0] {
    OUTCOME_HIT        = 2'd0,
    OUTCOME_BELOW_ZERO = 2'd1,
    OUTCOME_OUTSIDE    = 2'd2,
    OUTCOME_DEGENERATE = 2'd3
  } outcome_t;

endpackage
`default_nettype wire

### hw/rtl/vrth_div.sv
// Pipelined restoring divider, one quotient bit per stage, with the output register.
`default_nettype none
module vrth_div
  import vrth_pkg::*;
#(
  parameter int COORD_BITS = 24
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     d_valid,
  output logic                          d_stall,
  input  wire logic [3*COORD_BITS+6:0]  d_nt,
  input  wire logic [2*COORD_BITS+3:0]  d_m,
  input  wire outcome_t                 d_outcome,
  input  wire logic                     d_sat,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output outcome_t                      out_outcome,
  output logic [HEIGHT_BITS-1:0]        out_height
);

  localparam int NTW = 3*COORD_BITS+7;
  localparam int MNW = 2*COORD_BITS+4;
  localparam int HB  = HEIGHT_BITS;
  localparam int XW  = NTW + HB;

  logic                   v_r   [HB];
  logic [NTW-1:0]         rem_r [HB];
  logic [HB-1:0]          q_r   [HB];
  logic [MNW-1:0]         m_r   [HB];
  outcome_t               oc_r  [HB];
  logic                   sat_r [HB];
  logic                   rdy   [HB+1];

  logic                   out_valid_r;
  outcome_t               out_outcome_r;
  logic [HB-1:0]          out_height_r;

  assign rdy[HB] = !out_valid_r || !out_stall;

  genvar k;
  generate
    for (k = 0; k < HB; k++) begin : g_stage
      logic [NTW-1:0]   rem_in;
      logic [HB-1:0]    q_in;
      logic [MNW-1:0]   m_in;
      outcome_t         oc_in;
      logic             sat_in;
      logic             v_in;
      logic [XW-1:0]    trial;
      logic             take;
      logic [NTW-1:0]   rem_nxt;
      logic [HB-1:0]    q_nxt;

      if (k == 0) begin : g_first
        assign rem_in = d_nt;
        assign q_in   = '0;
        assign m_in   = d_m;
        assign oc_in  = d_outcome;
        assign sat_in = d_sat;
        assign v_in   = d_valid;
      end else begin : g_next
        assign rem_in = rem_r[k-1];
        assign q_in   = q_r[k-1];
        assign m_in   = m_r[k-1];
        assign oc_in  = oc_r[k-1];
        assign sat_in = sat_r[k-1];
        assign v_in   = v_r[k-1];
      end

      // divisor aligned to the quotient bit of this stage
      assign trial = XW'(m_in) << (HB-1-k);
      assign take  = XW'(rem_in) >= trial;

      always_comb begin
        rem_nxt = rem_in;
        q_nxt   = q_in;
        if (take) begin
          rem_nxt = NTW'(XW'(rem_in) - trial);
          q_nxt[HB-1-k] = 1'b1;
        end
      end

      assign rdy[k] = !v_r[k] || rdy[k+1];

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (rdy[k]) begin
          v_r[k] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[k]) begin
          rem_r[k] <= rem_nxt;
          q_r[k]   <= q_nxt;
          m_r[k]   <= m_in;
          oc_r[k]  <= oc_in;
          sat_r[k] <= sat_in;
        end
      end
    end
  endgenerate

  assign d_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy[HB]) begin
      out_valid_r <= v_r[HB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[HB]) begin
      out_outcome_r <= oc_r[HB-1];
      if (oc_r[HB-1] != OUTCOME_HIT) begin
        out_height_r <= '0;
      end else if (sat_r[HB-1]) begin
        out_height_r <= HEIGHT_MAX;
      end else begin
        out_height_r <= q_r[HB-1];
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_outcome = out_outcome_r;
  assign out_height  = out_height_r;

endmodule
`default_nettype wire

### hw/rtl/vertical_ray_triangle_height_core.sv
// Top level: vertical ray against triangle plane, exact fixed-point height.
`default_nettype none
// Takes one triangle and query point per word and returns one outcome and height per word,
// in order. Fully pipelined: a new word may enter every cycle unless the output stalls, and
// a word passes through 7 arithmetic stages for the determinants, the height numerator and
// the classification, 23 divider stages of one quotient bit each and one output register
// before its result appears. Each stage holds its word while the next is occupied and
// stalled, so bubbles are squeezed out. Heights carry the fraction bits of the inputs;
// quotients are truncated towards zero and saturate at the top of the height range.
module vertical_ray_triangle_height_core
  import vrth_pkg::*;
#(
  parameter int COORD_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_BITS-1:0]  in_vertex_a_x,
  input  wire logic signed [COORD_BITS-1:0]  in_vertex_a_y,
  input  wire logic signed [COORD_BITS-1:0]  in_vertex_a_z,
  input  wire logic signed [COORD_BITS-1:0]  in_vertex_b_x,
  input  wire logic signed [COORD_BITS-1:0]  in_vertex_b_y,
  input  wire logic signed [COORD_BITS-1:0]  in_vertex_b_z,
  input  wire logic signed [COORD_BITS-1:0]  in_vertex_c_x,
  input  wire logic signed [COORD_BITS-1:0]  in_vertex_c_y,
  input  wire logic signed [COORD_BITS-1:0]  in_vertex_c_z,
  input  wire logic signed [COORD_BITS-1:0]  in_query_x,
  input  wire logic signed [COORD_BITS-1:0]  in_query_y,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_outcome,
  output logic [HEIGHT_BITS-1:0]             out_height
);

  localparam int N   = COORD_BITS;
  localparam int DW  = N + 1;
  localparam int PW  = 2*N + 2;
  localparam int MW  = 2*N + 3;
  localparam int H   = N + 2;
  localparam int PPW = 2*N + 4;
  localparam int NTW = 3*N + 7;
  localparam int MNW = MW + 1;
  localparam int SW  = NTW + HEIGHT_BITS;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  logic r1, r2, r3, r4, r5, r6, r7;
  logic d_stall;
  outcome_t res_outcome;

  assign r7 = !v7_r || !d_stall;
  assign r6 = !v6_r || r7;
  assign r5 = !v5_r || r6;
  assign r4 = !v4_r || r5;
  assign r3 = !v3_r || r4;
  assign r2 = !v2_r || r3;
  assign r1 = !v1_r || r2;
  assign in_stall = !r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      if (r1) v1_r <= in_valid;
      if (r2) v2_r <= v1_r;
      if (r3) v3_r <= v2_r;
      if (r4) v4_r <= v3_r;
      if (r5) v5_r <= v4_r;
      if (r6) v6_r <= v5_r;
      if (r7) v7_r <= v6_r;
    end
  end

  // stage 1: edge and origin vectors
  logic signed [DW-1:0] ea_r, eb_r, ec_r, fd_r, fe_r, ff_r, oj_r, ok_r;
  logic signed [N-1:0]  ol_r;

  always_ff @(posedge clk) begin
    if (r1) begin
      ea_r <= DW'(in_vertex_a_x) - DW'(in_vertex_b_x);
      eb_r <= DW'(in_vertex_a_y) - DW'(in_vertex_b_y);
      ec_r <= DW'(in_vertex_a_z) - DW'(in_vertex_b_z);
      fd_r <= DW'(in_vertex_a_x) - DW'(in_vertex_c_x);
      fe_r <= DW'(in_vertex_a_y) - DW'(in_vertex_c_y);
      ff_r <= DW'(in_vertex_a_z) - DW'(in_vertex_c_z);
      oj_r <= DW'(in_vertex_a_x) - DW'(in_query_x);
      ok_r <= DW'(in_vertex_a_y) - DW'(in_query_y);
      ol_r <= in_vertex_a_z;
    end
  end

  // stage 2: 2x2 products
  logic signed [PW-1:0] p_ae_r, p_bd_r, p_ak_r, p_jb_r, p_je_r, p_kd_r;
  logic signed [DW-1:0] ec2_r, ff2_r;
  logic signed [N-1:0]  ol2_r;

  always_ff @(posedge clk) begin
    if (r2) begin
      p_ae_r <= PW'(ea_r) * PW'(fe_r);
      p_bd_r <= PW'(eb_r) * PW'(fd_r);
      p_ak_r <= PW'(ea_r) * PW'(ok_r);
      p_jb_r <= PW'(oj_r) * PW'(eb_r);
      p_je_r <= PW'(oj_r) * PW'(fe_r);
      p_kd_r <= PW'(ok_r) * PW'(fd_r);
      ec2_r  <= ec_r;
      ff2_r  <= ff_r;
      ol2_r  <= ol_r;
    end
  end

  // stage 3: determinant and barycentric numerators
  logic signed [MW-1:0] m3_r, ng3_r, nb3_r;
  logic signed [DW-1:0] ec3_r, ff3_r;
  logic signed [N-1:0]  ol3_r;

  always_ff @(posedge clk) begin
    if (r3) begin
      m3_r  <= MW'(p_ae_r) - MW'(p_bd_r);
      ng3_r <= MW'(p_ak_r) - MW'(p_jb_r);
      nb3_r <= MW'(p_je_r) - MW'(p_kd_r);
      ec3_r <= ec2_r;
      ff3_r <= ff2_r;
      ol3_r <= ol2_r;
    end
  end

  // stage 4: height numerator partial products, wide operand split in low and high halves
  logic signed [PPW-1:0] llo_r, lhi_r, clo_r, chi_r, flo_r, fhi_r;
  logic signed [MW-1:0]  m4_r, ng4_r, nb4_r;

  always_ff @(posedge clk) begin
    if (r4) begin
      llo_r <= PPW'(ol3_r) * PPW'($signed({1'b0, m3_r[H-1:0]}));
      lhi_r <= PPW'(ol3_r) * PPW'($signed(m3_r[MW-1:H]));
      clo_r <= PPW'(ec3_r) * PPW'($signed({1'b0, nb3_r[H-1:0]}));
      chi_r <= PPW'(ec3_r) * PPW'($signed(nb3_r[MW-1:H]));
      flo_r <= PPW'(ff3_r) * PPW'($signed({1'b0, ng3_r[H-1:0]}));
      fhi_r <= PPW'(ff3_r) * PPW'($signed(ng3_r[MW-1:H]));
      m4_r  <= m3_r;
      ng4_r <= ng3_r;
      nb4_r <= nb3_r;
    end
  end

  // stage 5: assemble height numerator
  logic signed [NTW-1:0] hsum, lsum;
  logic signed [NTW-1:0] nt5_r;
  logic signed [MW-1:0]  m5_r, ng5_r, nb5_r;

  assign hsum = NTW'(lhi_r) - NTW'(chi_r) - NTW'(fhi_r);
  assign lsum = NTW'(llo_r) - NTW'(clo_r) - NTW'(flo_r);

  always_ff @(posedge clk) begin
    if (r5) begin
      nt5_r <= (hsum <<< H) + lsum;
      m5_r  <= m4_r;
      ng5_r <= ng4_r;
      nb5_r <= nb4_r;
    end
  end

  // stage 6: make the determinant positive
  logic signed [NTW-1:0] nt6_r;
  logic signed [MNW-1:0] m6_r, ng6_r, nb6_r;
  logic                  zero6_r;

  always_ff @(posedge clk) begin
    if (r6) begin
      zero6_r <= (m5_r == '0);
      if (m5_r[MW-1]) begin
        nt6_r <= -nt5_r;
        m6_r  <= -MNW'(m5_r);
        ng6_r <= -MNW'(ng5_r);
        nb6_r <= -MNW'(nb5_r);
      end else begin
        nt6_r <= nt5_r;
        m6_r  <= MNW'(m5_r);
        ng6_r <= MNW'(ng5_r);
        nb6_r <= MNW'(nb5_r);
      end
    end
  end

  // stage 7: classify and check for quotient overflow
  logic signed [MNW:0]   bg_sum;
  logic [SW-1:0]         m_shift;
  logic                  sat_nxt;
  outcome_t              oc_nxt;
  logic [NTW-1:0]        nt7_r;
  logic [MNW-1:0]        m7_r;
  outcome_t              oc7_r;
  logic                  sat7_r;

  assign bg_sum  = (MNW+1)'(nb6_r) + (MNW+1)'(ng6_r);
  assign m_shift = SW'(m6_r) << HEIGHT_BITS;
  assign sat_nxt = SW'(nt6_r) >= m_shift;

  always_comb begin
    if (zero6_r) begin
      oc_nxt = OUTCOME_DEGENERATE;
    end else if (nt6_r < 0) begin
      oc_nxt = OUTCOME_BELOW_ZERO;
    end else if (ng6_r < 0 || ng6_r > m6_r || nb6_r < 0 || bg_sum > (MNW+1)'(m6_r)) begin
      oc_nxt = OUTCOME_OUTSIDE;
    end else begin
      oc_nxt = OUTCOME_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (r7) begin
      nt7_r  <= nt6_r;
      m7_r   <= m6_r;
      oc7_r  <= oc_nxt;
      sat7_r <= sat_nxt;
    end
  end

  vrth_div #(
    .COORD_BITS (COORD_BITS)
  ) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .d_valid     (v7_r),
    .d_stall     (d_stall),
    .d_nt        (nt7_r),
    .d_m         (m7_r),
    .d_outcome   (oc7_r),
    .d_sat       (sat7_r),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_outcome (res_outcome),
    .out_height  (out_height)
  );

  assign out_outcome = res_outcome;

endmodule
`default_nettype wire

### tb/tb_vertical_ray_triangle_height_core.sv
// Testbench for the vertical ray triangle height core: table-driven and random words, self-checked.
`timescale 1ns / 100ps
module tb_vertical_ray_triangle_height_core;
  import vrth_pkg::*;

  localparam int CB = 24;
  localparam int RANDOM_WORDS = 700;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic signed [CB-1:0] CMAX = 24'sh7FFFFF;
  localparam logic signed [CB-1:0] CMIN = -24'sh800000;

  typedef struct packed {
    logic signed [CB-1:0] ax, ay, az, bx, by, bz, cx, cy, cz, qx, qy;
  } tri_word_t;

  typedef struct packed {
    outcome_t               outcome;
    logic [HEIGHT_BITS-1:0] height;
  } height_res_t;

  typedef struct {
    tri_word_t   w;
    bit          typed;
    height_res_t res;
  } table_row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [CB-1:0] in_ax, in_ay, in_az, in_bx, in_by, in_bz, in_cx, in_cy, in_cz;
  logic signed [CB-1:0] in_qx, in_qy;
  logic [1:0] out_outcome;
  logic [HEIGHT_BITS-1:0] out_height;

  height_res_t heights_due[$];
  int errors = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int cycles = 0;
  int src_idle = 25;
  int snk_idle = 77;

  vertical_ray_triangle_height_core #(.COORD_BITS(CB)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_vertex_a_x(in_ax), .in_vertex_a_y(in_ay), .in_vertex_a_z(in_az),
    .in_vertex_b_x(in_bx), .in_vertex_b_y(in_by), .in_vertex_b_z(in_bz),
    .in_vertex_c_x(in_cx), .in_vertex_c_y(in_cy), .in_vertex_c_z(in_cz),
    .in_query_x(in_qx), .in_query_y(in_qy),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_outcome(out_outcome), .out_height(out_height)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // exact Cramer solve in 128-bit arithmetic
  function automatic height_res_t plane_height(tri_word_t w);
    logic signed [127:0] ea, eb, ec, fd, fe, ff, oj, ok, ol, m, ng, nb, nt, q;
    height_res_t r;
    ea = 128'(w.ax) - 128'(w.bx);
    eb = 128'(w.ay) - 128'(w.by);
    ec = 128'(w.az) - 128'(w.bz);
    fd = 128'(w.ax) - 128'(w.cx);
    fe = 128'(w.ay) - 128'(w.cy);
    ff = 128'(w.az) - 128'(w.cz);
    oj = 128'(w.ax) - 128'(w.qx);
    ok = 128'(w.ay) - 128'(w.qy);
    ol = 128'(w.az);
    m  = ea * fe - eb * fd;
    ng = ea * ok - oj * eb;
    nb = oj * fe - ok * fd;
    nt = ol * m - ec * nb - ff * ng;
    r.height = '0;
    if (m == 0) begin
      r.outcome = OUTCOME_DEGENERATE;
    end else begin
      if (m < 0) begin
        m = -m; ng = -ng; nb = -nb; nt = -nt;
      end
      if (nt < 0) begin
        r.outcome = OUTCOME_BELOW_ZERO;
      end else if (ng < 0 || ng > m || nb < 0 || nb + ng > m) begin
        r.outcome = OUTCOME_OUTSIDE;
      end else begin
        r.outcome = OUTCOME_HIT;
        q = nt / m;
        r.height = (q > 128'(HEIGHT_MAX)) ? HEIGHT_MAX : q[HEIGHT_BITS-1:0];
      end
    end
    return r;
  endfunction

  task automatic send_word(tri_word_t w, bit typed, height_res_t typed_res);
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_ax, in_ay, in_az, in_bx, in_by, in_bz, in_cx, in_cy, in_cz, in_qx, in_qy} <= w;
    do @(posedge clk); while (in_stall);
    heights_due.push_back(typed ? typed_res : plane_height(w));
  endtask

  function automatic logic signed [CB-1:0] rnd_coord(int span);
    return CB'($signed($urandom_range(2 * span)) - span);
  endfunction

  // mostly triangles queried at a vertex, an edge midpoint or near the centroid
  function automatic tri_word_t random_word();
    tri_word_t w;
    int span, pick;
    w = tri_word_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom});
    if ($urandom_range(99) < 30) return w;
    span = 1 << $urandom_range(22, 4);
    w.ax = rnd_coord(span); w.ay = rnd_coord(span);
    w.bx = rnd_coord(span); w.by = rnd_coord(span);
    w.cx = rnd_coord(span); w.cy = rnd_coord(span);
    w.az = rnd_coord(span); w.bz = rnd_coord(span); w.cz = rnd_coord(span);
    if ($urandom_range(3) != 0) begin
      w.az = w.az >>> 1; w.az[CB-1] = 1'b0; w.az[CB-2] = 1'b0;
      w.bz = w.bz >>> 1; w.bz[CB-1] = 1'b0; w.bz[CB-2] = 1'b0;
      w.cz = w.cz >>> 1; w.cz[CB-1] = 1'b0; w.cz[CB-2] = 1'b0;
    end
    pick = $urandom_range(3);
    case (pick)
      0: begin
        w.qx = w.bx; w.qy = w.by;
      end
      1: begin
        w.qx = CB'((28'(w.ax) + 28'(w.cx)) >>> 1); w.qy = CB'((28'(w.ay) + 28'(w.cy)) >>> 1);
      end
      default: begin
        w.qx = CB'((28'(w.ax) + 28'(w.bx) + 28'(w.cx)) / 3 + $signed($urandom_range(2)) - 1);
        w.qy = CB'((28'(w.ay) + 28'(w.by) + 28'(w.cy)) / 3 + $signed($urandom_range(2)) - 1);
      end
    endcase
    return w;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (heights_due.size() == 0) begin
          $display("%0t: unexpected word: outcome %0d height %0d", $time, out_outcome,
                   out_height);
          errors++;
        end else begin
          height_res_t e;
          e = heights_due.pop_front();
          if (e.outcome == OUTCOME_HIT) hits_seen++;
          if (out_outcome !== e.outcome) begin
            $display("%0t: outcome mismatch: expected %0d actual %0d", $time, e.outcome,
                     out_outcome);
            errors++;
          end
          if (out_height !== e.height) begin
            $display("%0t: height mismatch: expected %0d actual %0d", $time, e.height,
                     out_height);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < snk_idle);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d words outstanding", heights_due.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    table_row_t rows[$];
    table_row_t r;
    tri_word_t w;
    int n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    {in_ax, in_ay, in_az, in_bx, in_by, in_bz, in_cx, in_cy, in_cz, in_qx, in_qy} = '0;

    // all-zero triangle collapses
    r.w = '0; r.typed = 1; r.res = '{OUTCOME_DEGENERATE, '0}; rows.push_back(r);
    // flat unit triangle at height 1.0
    r.w = '{0, 0, 256, 256, 0, 256, 0, 256, 256, 0, 0};
    r.res = '{OUTCOME_HIT, 23'd256}; rows.push_back(r);
    r.w.qx = 512; r.w.qy = 512; r.res = '{OUTCOME_OUTSIDE, '0}; rows.push_back(r);
    r.w = '{0, 0, -256, 256, 0, -256, 0, 256, -256, 0, 0};
    r.res = '{OUTCOME_BELOW_ZERO, '0}; rows.push_back(r);
    // full-range triangle, top of the height range
    r.w = '{CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMIN};
    r.res = '{OUTCOME_HIT, HEIGHT_MAX}; rows.push_back(r);
    r.w.qx = CMAX; r.w.qy = CMAX; r.res = '{OUTCOME_OUTSIDE, '0}; rows.push_back(r);
    r.w = '{CMAX, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX};
    r.res = '{OUTCOME_DEGENERATE, '0}; rows.push_back(r);
    // collinear projection
    r.w = '{0, 0, 5, 256, 256, 7, 512, 512, 9, 256, 256};
    r.res = '{OUTCOME_DEGENERATE, '0}; rows.push_back(r);
    // rest from the predictor: slopes, edges, clockwise winding, truncation
    r.typed = 0;
    r.w = '{0, 0, 0, 256, 0, 256, 0, 256, 512, 85, 85}; rows.push_back(r);
    r.w = '{0, 0, 0, 0, 256, 256, 256, 0, 512, 128, 128}; rows.push_back(r);
    r.w = '{0, 0, 100, 300, 0, 1, 0, 700, 3, 150, 0}; rows.push_back(r);
    r.w = '{0, 0, 100, 300, 0, 1, 0, 700, 3, 0, 350}; rows.push_back(r);
    r.w = '{0, 0, 100, 300, 0, 1, 0, 700, 3, 151, 351}; rows.push_back(r);
    r.w = '{-5, -7, 11, 13, -3, 1, 2, 9, 10, 3, 0}; rows.push_back(r);
    r.w = '{0, 0, 10, 256, 0, -300, 0, 256, 40, 200, 50}; rows.push_back(r);
    r.w = '{CMIN, CMAX, 0, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, 0, 0}; rows.push_back(r);
    r.w = '{CMAX, CMAX, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, 0, CMAX, 0}; rows.push_back(r);
    r.w = '{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1}; rows.push_back(r);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].res);
    n = 0;
    while (n < RANDOM_WORDS) begin
      if (n == RANDOM_WORDS / 3) begin
        src_idle = 77; snk_idle = 25;
      end else if (n == 2 * RANDOM_WORDS / 3) begin
        src_idle = 0; snk_idle = 0;
      end
      w = random_word();
      send_word(w, 0, '0);
      n++;
    end
    in_valid <= 1'b0;

    while (heights_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d table rows and %0d random triangles, %0d words checked (%0d hits)",
             rows.size(), RANDOM_WORDS, results_seen, hits_seen);
    $display("under three stall/gap mixes on both channels");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
